// ===== sv/ctf_pkg.sv =====
package ctf_pkg;

    // Request codes carried in req_type.
    localparam logic [2:0] REQ_SWITCH   = 3'd0;
    localparam logic [2:0] REQ_PROC     = 3'd1;
    localparam logic [2:0] REQ_THREAD   = 3'd2;
    localparam logic [2:0] REQ_UNLOAD_P = 3'd3;
    localparam logic [2:0] REQ_UNLOAD_T = 3'd4;
    localparam logic [2:0] REQ_QUERY    = 3'd5;
    localparam logic [2:0] REQ_QUERY_DEC = 3'd6;
    localparam logic [2:0] REQ_FAULT    = 3'd7;

    // Only this privilege ring is traced.
    localparam logic [1:0] USER_RING = 2'd3;

    // Reset value of the fault status register.
    localparam logic [31:0] FAULT_CODE_RESET = 32'hC000_0005;

    // Default table sizes.
    localparam int PROC_ENTRIES_DEF   = 16;
    localparam int THREAD_ENTRIES_DEF = 16;

endpackage

// ===== sv/ctf_if.sv =====
// Event channel.
interface ctf_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] proc_id;
    logic [31:0] thread_id;
    logic        enable;
    logic [31:0] item_budget;
    logic [1:0]  privilege_level;
    logic [31:0] fault_status;

    modport source (output valid, req_type, proc_id, thread_id, enable, item_budget,
                    privilege_level, fault_status, input ready);
    modport sink (input valid, req_type, proc_id, thread_id, enable, item_budget,
                  privilege_level, fault_status, output ready);
endinterface

// Result channel.
interface ctf_rsp_if;
    logic valid;
    logic ready;
    logic is_traced;
    logic any_watched;
    logic table_full;

    modport source (output valid, is_traced, any_watched, table_full, input ready);
    modport sink (input valid, is_traced, any_watched, table_full, output ready);
endinterface

// Fault status register write channel.
interface ctf_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== sv/context_trace_filter.sv =====
// Channel   Role    Beat payload
// req       sink    req_type, proc_id, thread_id, enable, item_budget, privilege_level,
//                   fault_status
// rsp       source  is_traced, any_watched, table_full
// cfg       sink    data (fault status code)
//
// Every table walk reads one entry per cycle through a shared walk pointer. A table update
// takes one or two walks (none for a thread enable with zero budget; plus a write state for
// inserts), then a proc walk and a thread walk to refresh the trace flag. Queries that need
// no refresh go from idle straight to the result state.
// Reset clears all valid bits, the current context and the flag; no clearing pass.
// A new event is taken only in idle; a result waiting on rsp stalls only the next finish.
module context_trace_filter #(
    parameter int PROC_ENTRIES   = ctf_pkg::PROC_ENTRIES_DEF,
    parameter int THREAD_ENTRIES = ctf_pkg::THREAD_ENTRIES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ctf_req_if.sink   req,
    ctf_rsp_if.source rsp,
    ctf_cfg_if.sink   cfg
);
    import ctf_pkg::*;

    localparam int PW = (PROC_ENTRIES > 1) ? $clog2(PROC_ENTRIES) : 1;
    localparam int TW = (THREAD_ENTRIES > 1) ? $clog2(THREAD_ENTRIES) : 1;
    localparam int SW = (PW > TW) ? PW : TW;
    localparam logic [SW-1:0] P_LAST = SW'(PROC_ENTRIES - 1);
    localparam logic [SW-1:0] T_LAST = SW'(THREAD_ENTRIES - 1);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_OPP  = 9'b000000010,
        ST_OPPW = 9'b000000100,
        ST_OPT  = 9'b000001000,
        ST_OPTW = 9'b000010000,
        ST_EVP  = 9'b000100000,
        ST_EVT  = 9'b001000000,
        ST_EVW  = 9'b010000000,
        ST_DONE = 9'b100000000
    } state_t;

    state_t state_reg;

    // Latched event.
    logic [2:0]  req_type_reg;
    logic [31:0] pid_reg;
    logic [31:0] tid_reg;
    logic        en_reg;
    logic [31:0] budget_reg;

    logic [31:0] fault_code_reg;

    // Tables.
    logic [PROC_ENTRIES-1:0]   proc_valid_reg;
    logic [THREAD_ENTRIES-1:0] thread_valid_reg;
    logic [31:0] proc_keys   [PROC_ENTRIES];
    logic [63:0] thread_keys [THREAD_ENTRIES];
    logic [31:0] thread_budget [THREAD_ENTRIES];

    // Walk pointer and registered read data.
    logic [SW-1:0] idx_reg;
    logic [SW-1:0] cmp_idx_reg;
    logic          cmp_v_reg;
    logic [31:0]   rd_pkey_reg;
    logic [63:0]   rd_tkey_reg;
    logic [31:0]   rd_budget_reg;

    // Per-event walk results.
    logic          found_reg;
    logic [SW-1:0] found_idx_reg;
    logic          free_ok_reg;
    logic [SW-1:0] free_idx_reg;
    logic          full_reg;
    logic          ans_reg;
    logic          ev_hit_reg;
    logic          ev_found_reg;
    logic [TW-1:0] ev_slot_reg;
    logic [31:0]   ev_budget_reg;

    // Current context.
    logic [63:0]   ctx_reg;
    logic          slot_ok_reg;
    logic [TW-1:0] slot_reg;
    logic [31:0]   cur_budget_reg;
    logic          flag_reg;

    // Result register.
    logic rsp_valid_reg;
    logic rsp_traced_reg;
    logic rsp_any_reg;
    logic rsp_full_reg;

    logic          accept;
    logic          scan_state;
    logic          scan_last;
    logic [TW-1:0] cmp_t;
    logic [PW-1:0] cmp_p;
    logic          p_live;
    logic          t_live;
    logic [63:0]   ev_key;
    logic          bw_en;
    logic [TW-1:0] bw_addr;
    logic [31:0]   bw_data;
    logic          finish;

    assign req.ready  = (state_reg == ST_IDLE);
    assign accept     = req.valid && req.ready;
    assign cfg.ready  = 1'b1;
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.is_traced   = rsp_traced_reg;
    assign rsp.any_watched = rsp_any_reg;
    assign rsp.table_full  = rsp_full_reg;

    assign cmp_p  = cmp_idx_reg[PW-1:0];
    assign cmp_t  = cmp_idx_reg[TW-1:0];
    assign p_live = proc_valid_reg[cmp_p];
    assign t_live = thread_valid_reg[cmp_t];
    assign ev_key = {pid_reg, tid_reg};
    assign finish = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);

    // Walk states and the compare of their last entry.
    always_comb
    begin
        scan_state = (state_reg == ST_OPP) || (state_reg == ST_OPT) ||
                     (state_reg == ST_EVP) || (state_reg == ST_EVT);
        if ((state_reg == ST_OPP) || (state_reg == ST_EVP))
        begin
            scan_last = cmp_v_reg && (cmp_idx_reg == P_LAST);
        end
        else
        begin
            scan_last = cmp_v_reg && (cmp_idx_reg == T_LAST);
        end
    end

    // Budget store write port: decrementing query, thread insert, flag refresh.
    always_comb
    begin
        bw_en   = 1'b0;
        bw_addr = slot_reg;
        bw_data = cur_budget_reg - 32'd1;
        if (accept && (req.req_type == REQ_QUERY_DEC) && (req.privilege_level == USER_RING)
            && flag_reg && slot_ok_reg && (cur_budget_reg != 32'd0))
        begin
            bw_en = 1'b1;
        end
        else if (state_reg == ST_OPTW)
        begin
            bw_data = budget_reg;
            if (found_reg)
            begin
                bw_en   = 1'b1;
                bw_addr = found_idx_reg[TW-1:0];
            end
            else if (free_ok_reg)
            begin
                bw_en   = 1'b1;
                bw_addr = free_idx_reg[TW-1:0];
            end
        end
        else if ((state_reg == ST_EVW) && ev_found_reg && (ev_budget_reg != 32'd0))
        begin
            bw_en   = 1'b1;
            bw_addr = ev_slot_reg;
            bw_data = ev_budget_reg - 32'd1;
        end
    end

    // Key and budget stores with registered reads at the walk pointer.
    always_ff @(posedge clk)
    begin
        rd_pkey_reg   <= proc_keys[idx_reg[PW-1:0]];
        rd_tkey_reg   <= thread_keys[idx_reg[TW-1:0]];
        rd_budget_reg <= thread_budget[idx_reg[TW-1:0]];
        if ((state_reg == ST_OPPW) && !found_reg && free_ok_reg)
        begin
            proc_keys[free_idx_reg[PW-1:0]] <= pid_reg;
        end
        if ((state_reg == ST_OPTW) && !found_reg && free_ok_reg)
        begin
            thread_keys[free_idx_reg[TW-1:0]] <= ev_key;
        end
        if (bw_en)
        begin
            thread_budget[bw_addr] <= bw_data;
        end
    end

    // Walk pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            cmp_idx_reg <= '0;
            cmp_v_reg   <= 1'b0;
        end
        else if (!scan_state || scan_last)
        begin
            idx_reg     <= '0;
            cmp_idx_reg <= '0;
            cmp_v_reg   <= 1'b0;
        end
        else
        begin
            cmp_idx_reg <= idx_reg;
            cmp_v_reg   <= 1'b1;
            if (idx_reg != T_LAST && idx_reg != P_LAST)
            begin
                idx_reg <= idx_reg + SW'(1);
            end
            else if (((state_reg == ST_OPP) || (state_reg == ST_EVP)) && idx_reg != P_LAST)
            begin
                idx_reg <= idx_reg + SW'(1);
            end
            else if (((state_reg == ST_OPT) || (state_reg == ST_EVT)) && idx_reg != T_LAST)
            begin
                idx_reg <= idx_reg + SW'(1);
            end
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_code_reg <= FAULT_CODE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            fault_code_reg <= cfg.data;
        end
    end

    // Latched event fields.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= req.req_type;
            pid_reg      <= req.proc_id;
            tid_reg      <= req.thread_id;
            en_reg       <= req.enable;
            budget_reg   <= req.item_budget;
        end
    end

    // Sequencer, tables and context.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            proc_valid_reg   <= '0;
            thread_valid_reg <= '0;
            found_reg        <= 1'b0;
            found_idx_reg    <= '0;
            free_ok_reg      <= 1'b0;
            free_idx_reg     <= '0;
            full_reg         <= 1'b0;
            ans_reg          <= 1'b0;
            ev_hit_reg       <= 1'b0;
            ev_found_reg     <= 1'b0;
            ev_slot_reg      <= '0;
            ev_budget_reg    <= '0;
            ctx_reg          <= '0;
            slot_ok_reg      <= 1'b0;
            slot_reg         <= '0;
            cur_budget_reg   <= '0;
            flag_reg         <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            rsp_traced_reg   <= 1'b0;
            rsp_any_reg      <= 1'b0;
            rsp_full_reg     <= 1'b0;
        end
        else
        begin
            // A beat taken in the same cycle as a new finish is replaced below.
            if (rsp_valid_reg && rsp.ready && !finish)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    found_reg    <= 1'b0;
                    free_ok_reg  <= 1'b0;
                    full_reg     <= 1'b0;
                    ev_hit_reg   <= 1'b0;
                    ev_found_reg <= 1'b0;
                    if (accept)
                    begin
                        unique case (req.req_type)
                            REQ_SWITCH:
                            begin
                                ctx_reg   <= {req.proc_id, req.thread_id};
                                state_reg <= ST_EVP;
                            end
                            REQ_PROC, REQ_UNLOAD_P:
                            begin
                                state_reg <= ST_OPP;
                            end
                            REQ_THREAD:
                            begin
                                if (req.enable && (req.item_budget == 32'd0))
                                begin
                                    state_reg <= ST_EVP;
                                end
                                else
                                begin
                                    state_reg <= ST_OPT;
                                end
                            end
                            REQ_UNLOAD_T:
                            begin
                                state_reg <= ST_OPT;
                            end
                            REQ_QUERY:
                            begin
                                ans_reg   <= (req.privilege_level == USER_RING) && flag_reg;
                                state_reg <= ST_DONE;
                            end
                            REQ_QUERY_DEC:
                            begin
                                priority if ((req.privilege_level != USER_RING) || !flag_reg)
                                begin
                                    ans_reg   <= 1'b0;
                                    state_reg <= ST_DONE;
                                end
                                else if (slot_ok_reg && (cur_budget_reg != 32'd0))
                                begin
                                    cur_budget_reg <= cur_budget_reg - 32'd1;
                                    ans_reg        <= 1'b1;
                                    state_reg      <= ST_DONE;
                                end
                                else if (slot_ok_reg)
                                begin
                                    // Exhausted entry: drop it and refresh the flag.
                                    thread_valid_reg[slot_reg] <= 1'b0;
                                    state_reg                  <= ST_EVP;
                                end
                                else
                                begin
                                    ans_reg   <= 1'b1;
                                    state_reg <= ST_DONE;
                                end
                            end
                            REQ_FAULT:
                            begin
                                if (flag_reg && (req.fault_status == fault_code_reg))
                                begin
                                    if (slot_ok_reg)
                                    begin
                                        thread_valid_reg[slot_reg] <= 1'b0;
                                    end
                                    state_reg <= ST_EVP;
                                end
                                else
                                begin
                                    ans_reg   <= flag_reg;
                                    state_reg <= ST_DONE;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end

                // Process table walk for enable, disable and unload.
                ST_OPP:
                begin
                    if (cmp_v_reg)
                    begin
                        if (p_live && (rd_pkey_reg == pid_reg))
                        begin
                            if ((req_type_reg == REQ_PROC) && en_reg)
                            begin
                                found_reg <= 1'b1;
                            end
                            else
                            begin
                                proc_valid_reg[cmp_p] <= 1'b0;
                            end
                        end
                        if (!p_live && !free_ok_reg)
                        begin
                            free_ok_reg  <= 1'b1;
                            free_idx_reg <= cmp_idx_reg;
                        end
                    end
                    if (scan_last)
                    begin
                        priority if ((req_type_reg == REQ_PROC) && en_reg)
                        begin
                            state_reg <= ST_OPPW;
                        end
                        else if (req_type_reg == REQ_UNLOAD_P)
                        begin
                            state_reg <= ST_OPT;
                        end
                        else
                        begin
                            state_reg <= ST_EVP;
                        end
                    end
                end

                ST_OPPW:
                begin
                    if (!found_reg)
                    begin
                        if (free_ok_reg)
                        begin
                            proc_valid_reg[free_idx_reg[PW-1:0]] <= 1'b1;
                        end
                        else
                        begin
                            full_reg <= 1'b1;
                        end
                    end
                    state_reg <= ST_EVP;
                end

                // Thread table walk for enable, disable and both unloads.
                ST_OPT:
                begin
                    if (cmp_v_reg)
                    begin
                        priority if (req_type_reg == REQ_UNLOAD_P)
                        begin
                            if (t_live && (rd_tkey_reg[63:32] == pid_reg))
                            begin
                                thread_valid_reg[cmp_t] <= 1'b0;
                            end
                        end
                        else if ((req_type_reg == REQ_THREAD) && en_reg)
                        begin
                            if (t_live && (rd_tkey_reg == ev_key))
                            begin
                                found_reg     <= 1'b1;
                                found_idx_reg <= cmp_idx_reg;
                            end
                            if (!t_live && !free_ok_reg)
                            begin
                                free_ok_reg  <= 1'b1;
                                free_idx_reg <= cmp_idx_reg;
                            end
                        end
                        else
                        begin
                            if (t_live && (rd_tkey_reg == ev_key))
                            begin
                                thread_valid_reg[cmp_t] <= 1'b0;
                            end
                        end
                    end
                    if (scan_last)
                    begin
                        if ((req_type_reg == REQ_THREAD) && en_reg)
                        begin
                            state_reg <= ST_OPTW;
                        end
                        else
                        begin
                            state_reg <= ST_EVP;
                        end
                    end
                end

                ST_OPTW:
                begin
                    if (!found_reg)
                    begin
                        if (free_ok_reg)
                        begin
                            thread_valid_reg[free_idx_reg[TW-1:0]] <= 1'b1;
                        end
                        else
                        begin
                            full_reg <= 1'b1;
                        end
                    end
                    state_reg <= ST_EVP;
                end

                // Flag refresh: is the current process watched?
                ST_EVP:
                begin
                    if (cmp_v_reg && p_live && (rd_pkey_reg == ctx_reg[63:32]))
                    begin
                        ev_hit_reg <= 1'b1;
                    end
                    if (scan_last)
                    begin
                        state_reg <= ST_EVT;
                    end
                end

                // Flag refresh: locate the current pair's entry.
                ST_EVT:
                begin
                    if (cmp_v_reg && t_live && (rd_tkey_reg == ctx_reg))
                    begin
                        ev_found_reg  <= 1'b1;
                        ev_slot_reg   <= cmp_t;
                        ev_budget_reg <= rd_budget_reg;
                    end
                    if (scan_last)
                    begin
                        state_reg <= ST_EVW;
                    end
                end

                // Commit the refreshed flag and spend one budget item.
                ST_EVW:
                begin
                    slot_ok_reg <= ev_found_reg;
                    slot_reg    <= ev_found_reg ? ev_slot_reg : '0;
                    if (ev_found_reg && (ev_budget_reg != 32'd0))
                    begin
                        cur_budget_reg <= ev_budget_reg - 32'd1;
                        flag_reg       <= 1'b1;
                        ans_reg        <= (req_type_reg != REQ_QUERY_DEC);
                    end
                    else
                    begin
                        cur_budget_reg <= ev_budget_reg;
                        flag_reg       <= ev_hit_reg;
                        ans_reg        <= ev_hit_reg && (req_type_reg != REQ_QUERY_DEC);
                    end
                    state_reg <= ST_DONE;
                end

                ST_DONE:
                begin
                    if (finish)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_traced_reg <= ans_reg;
                        rsp_any_reg    <= (|proc_valid_reg) || (|thread_valid_reg);
                        rsp_full_reg   <= full_reg;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The sequencer is always in exactly one state.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    // Between events the current slot points at a live thread entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && slot_ok_reg) |-> thread_valid_reg[slot_reg])
        else $error("current slot points at an empty entry");

    // A live budget on the current pair always means the flag is set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && slot_ok_reg && cur_budget_reg != 32'd0) |-> flag_reg)
        else $error("budget left but trace flag clear");

    // Only inserts can report a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && full_reg) |->
            (req_type_reg == REQ_PROC || req_type_reg == REQ_THREAD))
        else $error("table full flagged on a non-insert event");

endmodule

// ===== tb/context_trace_filter_tb.sv =====
module context_trace_filter_tb;
    import ctf_pkg::*;

    localparam int NPROC   = PROC_ENTRIES_DEF;
    localparam int NTHREAD = THREAD_ENTRIES_DEF;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASE_ITEMS = 210;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] proc_id;
        logic [31:0] thread_id;
        logic        enable;
        logic [31:0] item_budget;
        logic [1:0]  privilege_level;
        logic [31:0] fault_status;
    } event_t;

    typedef struct packed {
        logic is_traced;
        logic any_watched;
        logic table_full;
    } verdict_t;

    typedef struct packed {
        event_t   ev;
        logic     typed;
        verdict_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ctf_req_if req ();
    ctf_rsp_if rsp ();
    ctf_cfg_if cfg ();

    context_trace_filter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always #6 clk = ~clk;

    // Shadow copy of the filter state.
    logic        w_proc_valid [NPROC];
    logic [31:0] w_proc_key [NPROC];
    logic        w_thr_valid [NTHREAD];
    logic [63:0] w_thr_key [NTHREAD];
    logic [31:0] w_thr_budget [NTHREAD];
    logic [63:0] w_context;
    logic        w_slot_ok;
    int          w_slot;
    logic        w_flag;
    logic [31:0] w_fault_code;

    verdict_t verdicts_due [$];
    int errors = 0;
    int events_sent = 0;
    int verdicts_seen = 0;
    int full_seen = 0;
    int traced_seen = 0;
    int quiet = 0;
    bit no_idle = 0;
    bit hold_req = 0;

    logic [31:0] pid_pool [20];
    logic [31:0] tid_pool [6];

    function automatic int find_proc(logic [31:0] id);
        for (int i = 0; i < NPROC; i++)
            if (w_proc_valid[i] && w_proc_key[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int find_thread(logic [63:0] key);
        for (int i = 0; i < NTHREAD; i++)
            if (w_thr_valid[i] && w_thr_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic void drop_thread(logic [63:0] key);
        int i;
        i = find_thread(key);
        if (i >= 0)
            w_thr_valid[i] = 1'b0;
    endfunction

    // Recompute the trace flag; a matching thread budget is spent once.
    function automatic void refresh_flag();
        logic t;
        int i;
        t = (find_proc(w_context[63:32]) >= 0);
        i = find_thread(w_context);
        w_slot_ok = 1'b0;
        w_slot = 0;
        if (i >= 0)
        begin
            w_slot_ok = 1'b1;
            w_slot = i;
            if (w_thr_budget[i] > 0)
            begin
                w_thr_budget[i] = w_thr_budget[i] - 1;
                t = 1'b1;
            end
        end
        w_flag = t;
    endfunction

    function automatic void clear_shadow();
        for (int i = 0; i < NPROC; i++)
            w_proc_valid[i] = 1'b0;
        for (int i = 0; i < NTHREAD; i++)
            w_thr_valid[i] = 1'b0;
        w_context = '0;
        w_slot_ok = 1'b0;
        w_slot = 0;
        w_flag = 1'b0;
        w_fault_code = FAULT_CODE_RESET;
    endfunction

    function automatic verdict_t trace_verdict(event_t ev);
        verdict_t v;
        logic [63:0] key;
        logic answer;
        logic full;
        int i;
        int j;
        key = {ev.proc_id, ev.thread_id};
        answer = 1'b0;
        full = 1'b0;
        case (ev.req_type)
            REQ_SWITCH:
            begin
                w_context = key;
                refresh_flag();
                answer = w_flag;
            end
            REQ_PROC:
            begin
                i = find_proc(ev.proc_id);
                if (ev.enable)
                begin
                    if (i < 0)
                    begin
                        for (j = 0; j < NPROC && w_proc_valid[j]; j++)
                            ;
                        if (j < NPROC)
                        begin
                            w_proc_valid[j] = 1'b1;
                            w_proc_key[j] = ev.proc_id;
                        end
                        else
                            full = 1'b1;
                    end
                end
                else if (i >= 0)
                    w_proc_valid[i] = 1'b0;
                refresh_flag();
                answer = w_flag;
            end
            REQ_THREAD:
            begin
                if (ev.enable)
                begin
                    if (ev.item_budget > 0)
                    begin
                        i = find_thread(key);
                        if (i < 0)
                        begin
                            for (j = 0; j < NTHREAD && w_thr_valid[j]; j++)
                                ;
                            if (j < NTHREAD)
                            begin
                                i = j;
                                w_thr_valid[i] = 1'b1;
                                w_thr_key[i] = key;
                            end
                            else
                                full = 1'b1;
                        end
                        if (i >= 0)
                            w_thr_budget[i] = ev.item_budget;
                    end
                end
                else
                    drop_thread(key);
                refresh_flag();
                answer = w_flag;
            end
            REQ_UNLOAD_P:
            begin
                i = find_proc(ev.proc_id);
                if (i >= 0)
                    w_proc_valid[i] = 1'b0;
                for (j = 0; j < NTHREAD; j++)
                    if (w_thr_valid[j] && w_thr_key[j][63:32] == ev.proc_id)
                        w_thr_valid[j] = 1'b0;
                refresh_flag();
                answer = w_flag;
            end
            REQ_UNLOAD_T:
            begin
                drop_thread(key);
                refresh_flag();
                answer = w_flag;
            end
            REQ_QUERY:
                answer = (ev.privilege_level == USER_RING) && w_flag;
            REQ_QUERY_DEC:
            begin
                if (ev.privilege_level != USER_RING || !w_flag)
                    answer = 1'b0;
                else if (w_slot_ok && w_thr_valid[w_slot])
                begin
                    if (w_thr_budget[w_slot] > 0)
                    begin
                        w_thr_budget[w_slot] = w_thr_budget[w_slot] - 1;
                        answer = 1'b1;
                    end
                    else
                    begin
                        drop_thread(w_context);
                        refresh_flag();
                        answer = 1'b0;
                    end
                end
                else
                    answer = 1'b1;
            end
            default:
            begin
                if (w_flag && ev.fault_status == w_fault_code)
                begin
                    drop_thread(w_context);
                    refresh_flag();
                end
                answer = w_flag;
            end
        endcase
        v.is_traced = answer;
        v.any_watched = 1'b0;
        for (i = 0; i < NPROC; i++)
            if (w_proc_valid[i])
                v.any_watched = 1'b1;
        for (i = 0; i < NTHREAD; i++)
            if (w_thr_valid[i])
                v.any_watched = 1'b1;
        v.table_full = full;
        return v;
    endfunction

    function automatic event_t make_event(logic [2:0] op, logic [31:0] pid, logic [31:0] tid,
                                          logic en, logic [31:0] budget, logic [1:0] ring,
                                          logic [31:0] status);
        event_t ev;
        ev.req_type = op;
        ev.proc_id = pid;
        ev.thread_id = tid;
        ev.enable = en;
        ev.item_budget = budget;
        ev.privilege_level = ring;
        ev.fault_status = status;
        return ev;
    endfunction

    // Mostly pooled ids so that entries get hit, filled and reused; some noise.
    function automatic event_t random_event();
        event_t ev;
        int r;
        r = $urandom_range(0, 99);
        ev.req_type = (r < 18) ? REQ_SWITCH :
                      (r < 32) ? REQ_PROC :
                      (r < 50) ? REQ_THREAD :
                      (r < 54) ? REQ_UNLOAD_P :
                      (r < 60) ? REQ_UNLOAD_T :
                      (r < 72) ? REQ_QUERY :
                      (r < 90) ? REQ_QUERY_DEC : REQ_FAULT;
        ev.thread_id = tid_pool[$urandom_range(0, 5)];
        if (ev.req_type == REQ_PROC)
            ev.proc_id = pid_pool[$urandom_range(0, 19)];
        else
            ev.proc_id = pid_pool[$urandom_range(0, 4)];
        ev.enable = ($urandom_range(0, 3) != 0);
        ev.item_budget = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3);
        ev.privilege_level = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 2)) : USER_RING;
        ev.fault_status = ($urandom_range(0, 1) == 0) ? w_fault_code : $urandom;
        if ($urandom_range(0, 9) == 0)
        begin
            ev.proc_id = $urandom;
            ev.thread_id = $urandom;
            ev.item_budget = $urandom;
            ev.fault_status = $urandom;
        end
        return ev;
    endfunction

    // Offer one event beat and record what it must produce.
    task automatic send_event(event_t ev, logic typed, verdict_t want);
        verdict_t v;
        req.valid <= 1'b1;
        req.req_type <= ev.req_type;
        req.proc_id <= ev.proc_id;
        req.thread_id <= ev.thread_id;
        req.enable <= ev.enable;
        req.item_budget <= ev.item_budget;
        req.privilege_level <= ev.privilege_level;
        req.fault_status <= ev.fault_status;
        do
            @(posedge clk);
        while (!req.ready);
        v = trace_verdict(ev);
        verdicts_due.push_back(typed ? want : v);
        events_sent++;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Fault code register write, only with the filter drained.
    task automatic write_fault_code(logic [31:0] code);
        req.valid <= 1'b0;
        @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data <= code;
        do
            @(posedge clk);
        while (!cfg.ready);
        w_fault_code = code;
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Result side: random ready bursts plus one long hold-off on request.
    initial
    begin
        int k;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                rsp.ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
                hold_req = 0;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            verdicts_seen++;
            if (rsp.is_traced)
                traced_seen++;
            if (rsp.table_full)
                full_seen++;
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected result beat %b%b%b", $realtime,
                         rsp.is_traced, rsp.any_watched, rsp.table_full);
                errors++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (rsp.is_traced !== want.is_traced)
                begin
                    $display("%0t: is_traced expected %b actual %b", $realtime,
                             want.is_traced, rsp.is_traced);
                    errors++;
                end
                if (rsp.any_watched !== want.any_watched)
                begin
                    $display("%0t: any_watched expected %b actual %b", $realtime,
                             want.any_watched, rsp.any_watched);
                    errors++;
                end
                if (rsp.table_full !== want.table_full)
                begin
                    $display("%0t: table_full expected %b actual %b", $realtime,
                             want.table_full, rsp.table_full);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat on any channel.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $realtime, quiet);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        row_t rows [$];
        verdict_t none;
        logic [31:0] codes [4];
        logic [31:0] rc;
        none = '0;
        rc = FAULT_CODE_RESET;
        req.valid <= 1'b0;
        req.req_type <= REQ_SWITCH;
        req.proc_id <= '0;
        req.thread_id <= '0;
        req.enable <= 1'b0;
        req.item_budget <= '0;
        req.privilege_level <= '0;
        req.fault_status <= '0;
        cfg.valid <= 1'b0;
        cfg.data <= '0;
        clear_shadow();
        for (int i = 0; i < 20; i++)
            pid_pool[i] = i;
        pid_pool[0] = 32'hFFFF_FFFF;
        pid_pool[4] = 32'h8000_0000;
        for (int i = 0; i < 6; i++)
            tid_pool[i] = i * 3;
        tid_pool[5] = 32'hFFFF_FFFF;

        // Directed events; typed expectations where they are plain.
        rows.push_back('{make_event(REQ_QUERY, 0, 0, 0, 0, USER_RING, 0), 1, 3'b000});
        rows.push_back('{make_event(REQ_SWITCH, 1, 1, 0, 0, 0, 0), 1, 3'b000});
        rows.push_back('{make_event(REQ_PROC, 1, 0, 1, 0, 0, 0), 1, 3'b110});
        rows.push_back('{make_event(REQ_QUERY, 0, 0, 0, 0, 2'd0, 0), 1, 3'b010});
        rows.push_back('{make_event(REQ_QUERY, 0, 0, 0, 0, USER_RING, 0), 1, 3'b110});
        rows.push_back('{make_event(REQ_QUERY_DEC, 0, 0, 0, 0, USER_RING, 0), 1, 3'b110});
        rows.push_back('{make_event(REQ_THREAD, 2, 32'hFFFF_FFFF, 1, 0, 0, 0), 0, none});
        rows.push_back('{make_event(REQ_THREAD, 1, 1, 1, 2, 0, 0), 0, none});
        rows.push_back('{make_event(REQ_PROC, 1, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{make_event(REQ_QUERY_DEC, 0, 0, 0, 0, USER_RING, 0), 0, none});
        rows.push_back('{make_event(REQ_QUERY_DEC, 0, 0, 0, 0, USER_RING, 0), 0, none});
        rows.push_back('{make_event(REQ_QUERY_DEC, 0, 0, 0, 0, USER_RING, 0), 0, none});
        rows.push_back('{make_event(REQ_THREAD, 32'hFFFF_FFFF, 0, 1, 32'hFFFF_FFFF, 3, 0),
                         0, none});
        rows.push_back('{make_event(REQ_SWITCH, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{make_event(REQ_FAULT, 0, 0, 0, 0, 0, 32'h1234_5678), 0, none});
        rows.push_back('{make_event(REQ_FAULT, 0, 0, 0, 0, 0, rc), 0, none});
        rows.push_back('{make_event(REQ_UNLOAD_T, 7, 7, 0, 0, 0, 0), 0, none});
        rows.push_back('{make_event(REQ_PROC, 32'hFFFF_FFFF, 0, 1, 0, 0, 0), 0, none});
        rows.push_back('{make_event(REQ_PROC, 32'hFFFF_FFFF, 0, 1, 0, 0, 0), 0, none});
        rows.push_back('{make_event(REQ_THREAD, 32'hFFFF_FFFF, 5, 1, 1, 0, 0), 0, none});
        rows.push_back('{make_event(REQ_THREAD, 32'hFFFF_FFFF, 5, 1, 9, 0, 0), 0, none});
        rows.push_back('{make_event(REQ_UNLOAD_P, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{make_event(REQ_THREAD, 1, 1, 0, 0, 0, 0), 0, none});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_event(rows[i].ev, rows[i].typed, rows[i].want);

        // Random phases, each behind its own fault code setting.
        codes[0] = 32'h0;
        codes[1] = 32'hFFFF_FFFF;
        codes[2] = $urandom;
        codes[3] = FAULT_CODE_RESET;
        for (int p = 0; p < 4; p++)
        begin
            write_fault_code(codes[p]);
            if (p == 3)
                no_idle = 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 1 && n == 40)
                    hold_req = 1;
                send_event(random_event(), 1'b0, none);
            end
        end
        req.valid <= 1'b0;

        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (verdicts_due.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $realtime,
                     verdicts_due.size());
            errors++;
        end
        $display("Sent %0d events over four fault code settings; %0d results checked.",
                 events_sent, verdicts_seen);
        $display("Traced answers: %0d, dropped inserts: %0d, mismatches: %0d.",
                 traced_seen, full_seen, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
